// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the unescaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: label");
// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMP(label, clk, rst_n, a, c)
`define ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/bhu_pkg.sv -----
// Types, character codes and hex helpers for the backslash hex unescaper.
package bhu_pkg;

    localparam logic [7:0] BS_CHAR    = 8'h5C;
    localparam logic [7:0] X_CHAR     = 8'h78;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] LC_A_CHAR  = 8'h61;
    localparam logic [7:0] UC_A_CHAR  = 8'h41;
    localparam logic [7:0] LC_A_BIAS  = 8'd87; // 'a' - 10
    localparam logic [7:0] UC_A_BIAS  = 8'd55; // 'A' - 10
    localparam int unsigned MAX_OUT   = 4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BS     = 2'd1,
        PH_BS_X   = 2'd2,
        PH_DIGIT  = 2'd3
    } t_phase;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= LC_A_CHAR) begin
            v = c - LC_A_BIAS;
        end else if (c >= UC_A_CHAR) begin
            v = c - UC_A_BIAS;
        end else begin
            v = c - ZERO_CHAR;
        end
        return v[3:0];
    endfunction

endpackage

// ----- hw/rtl/backslash_hex_unescaper.sv -----
// Top level of the backslash hex unescaper: input register, decode, result buffer.

// Removes backslash escapes from a byte stream: "\c" gives c, "\xHH" gives the
// byte 0xHH, and an incomplete hex escape or one cut off by end of string is
// passed on unchanged. An input item enters an input register, is decoded
// against the escape state in one pass and drops its 0 to 4 result bytes into
// a four-entry result buffer that drains one byte per cycle while the output
// is ready. One input item per cycle is sustained while each input gives at most
// one result and the output does not stall; the next input is decoded in the
// cycle the buffer hands out its last byte.
`include "assert_macros.svh"

module backslash_hex_unescaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_end
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // run_last
    output logic       o_m_axis_tlast    // string_end
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    // escape state
    bhu_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_held, n_held;

    // result buffer
    logic        r_bvalid;
    logic [7:0]  r_bytes [bhu_pkg::MAX_OUT];
    logic [2:0]  r_cnt;
    logic [1:0]  r_pos;
    logic        r_end;

    logic [7:0]  n_lst [bhu_pkg::MAX_OUT];
    logic [2:0]  n_cnt;
    logic        take_c;
    logic        out_fire;
    logic        buf_done;
    logic        move;
    logic [2:0]  pos_ext;

    assign pos_ext         = {1'b0, r_pos};
    assign o_m_axis_tvalid = r_bvalid;
    assign o_m_axis_tdata  = r_bytes[r_pos];
    assign o_m_axis_tuser  = (pos_ext == r_cnt - 3'd1);
    assign o_m_axis_tlast  = o_m_axis_tuser & r_end;

    assign out_fire = r_bvalid & i_m_axis_tready;
    assign buf_done = !r_bvalid || (out_fire && o_m_axis_tuser);
    assign move     = r_in_valid & buf_done;
    assign o_s_axis_tready = !r_in_valid || buf_done;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_cnt   = 3'd0;
        take_c  = 1'b0;
        for (int i = 0; i < bhu_pkg::MAX_OUT; i++) begin
            n_lst[i] = 8'h00;
        end

        case (r_phase)
            bhu_pkg::PH_IDLE: begin
                take_c = 1'b1;
            end
            bhu_pkg::PH_BS: begin
                if (r_in_byte == bhu_pkg::X_CHAR) begin
                    n_phase = bhu_pkg::PH_BS_X;
                end else begin
                    n_phase = bhu_pkg::PH_IDLE;
                    n_lst[n_cnt[1:0]] = r_in_byte;
                    n_cnt = n_cnt + 3'd1;
                end
            end
            bhu_pkg::PH_BS_X: begin
                if (bhu_pkg::is_hex(r_in_byte)) begin
                    n_held  = r_in_byte;
                    n_phase = bhu_pkg::PH_DIGIT;
                end else begin
                    n_lst[n_cnt[1:0]] = bhu_pkg::BS_CHAR;
                    n_cnt = n_cnt + 3'd1;
                    n_lst[n_cnt[1:0]] = bhu_pkg::X_CHAR;
                    n_cnt = n_cnt + 3'd1;
                    n_phase = bhu_pkg::PH_IDLE;
                    take_c  = 1'b1;
                end
            end
            bhu_pkg::PH_DIGIT: begin
                if (bhu_pkg::is_hex(r_in_byte)) begin
                    n_lst[n_cnt[1:0]] = {bhu_pkg::hex_value(r_held),
                                         bhu_pkg::hex_value(r_in_byte)};
                    n_cnt = n_cnt + 3'd1;
                end else begin
                    n_lst[n_cnt[1:0]] = bhu_pkg::BS_CHAR;
                    n_cnt = n_cnt + 3'd1;
                    n_lst[n_cnt[1:0]] = bhu_pkg::X_CHAR;
                    n_cnt = n_cnt + 3'd1;
                    n_lst[n_cnt[1:0]] = r_held;
                    n_cnt = n_cnt + 3'd1;
                    take_c = 1'b1;
                end
                n_phase = bhu_pkg::PH_IDLE;
                n_held  = 8'h00;
            end
            default: begin
                n_phase = bhu_pkg::PH_IDLE;
            end
        endcase

        // offending or plain byte seen from idle
        if (take_c) begin
            if (r_in_byte == bhu_pkg::BS_CHAR) begin
                n_phase = bhu_pkg::PH_BS;
            end else begin
                n_lst[n_cnt[1:0]] = r_in_byte;
                n_cnt = n_cnt + 3'd1;
            end
        end

        // end of string: flush whatever is held
        if (r_in_end) begin
            if (n_phase != bhu_pkg::PH_IDLE) begin
                n_lst[n_cnt[1:0]] = bhu_pkg::BS_CHAR;
                n_cnt = n_cnt + 3'd1;
            end
            if (n_phase == bhu_pkg::PH_BS_X || n_phase == bhu_pkg::PH_DIGIT) begin
                n_lst[n_cnt[1:0]] = bhu_pkg::X_CHAR;
                n_cnt = n_cnt + 3'd1;
            end
            if (n_phase == bhu_pkg::PH_DIGIT) begin
                n_lst[n_cnt[1:0]] = n_held;
                n_cnt = n_cnt + 3'd1;
            end
            n_phase = bhu_pkg::PH_IDLE;
            n_held  = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bhu_pkg::PH_IDLE;
            r_held  <= 8'h00;
        end else if (move) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
            r_pos    <= 2'd0;
            r_cnt    <= 3'd0;
        end else if (move) begin
            r_bvalid <= (n_cnt != 3'd0);
            r_pos    <= 2'd0;
            r_cnt    <= n_cnt;
        end else if (out_fire) begin
            if (o_m_axis_tuser) begin
                r_bvalid <= 1'b0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_bytes <= n_lst;
            r_end   <= r_in_end;
        end
    end

    `ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, r_bvalid, pos_ext < r_cnt)
    `ASSERT_IMP(a_buf_nonempty, i_clk, i_rst_n, r_bvalid, r_cnt != 3'd0 && r_cnt <= 3'd4)
    `ASSERT_NXT(a_end_idle, i_clk, i_rst_n, move && r_in_end, r_phase == bhu_pkg::PH_IDLE)
    `ASSERT_NXT(a_end_result, i_clk, i_rst_n, move && r_in_end, r_bvalid && r_end)

endmodule

// ----- verif/testbench.sv -----
// Self-checking stream testbench for the backslash hex unescaper.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_raw_char;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       str_end;
    } t_plain_char;

    localparam int unsigned RANDOM_CHARS = 144;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] in_data = 8'h00;
    logic in_last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_data;
    logic out_run_last;
    logic out_str_end;

    t_raw_char   raw_chars[$];      // items still to be sent
    t_plain_char plain_chars[$];    // decoded bytes still to arrive
    t_plain_char want;

    // predictor state
    bhu_pkg::t_phase esc_phase = bhu_pkg::PH_IDLE;
    logic [7:0] held_char = 8'h00;

    int unsigned errors = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned mask_age = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    int unsigned directed_count;
    int unsigned pick;
    logic [7:0] c;

    backslash_hex_unescaper u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),      // [7:0] in_byte
        .i_s_axis_tlast  (in_last),      // in_end
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),     // [7:0] out_byte
        .o_m_axis_tuser  (out_run_last), // run_last
        .o_m_axis_tlast  (out_str_end)   // string_end
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return {1'b1, ch[3:0]};
        end
        if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
            return {1'b1, ch[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic predict_unescape(input logic [7:0] ch, input logic fin);
        logic [7:0] outs[$];
        logic [4:0] lo_nib;
        logic [4:0] hi_nib;
        logic       fresh;
        t_plain_char r;
        lo_nib = hex_nibble(ch);
        hi_nib = hex_nibble(held_char);
        fresh = 1'b0;
        case (esc_phase)
            bhu_pkg::PH_IDLE: fresh = 1'b1;
            bhu_pkg::PH_BS: begin
                esc_phase = bhu_pkg::PH_IDLE;
                if (ch == bhu_pkg::X_CHAR) begin
                    esc_phase = bhu_pkg::PH_BS_X;
                end else begin
                    outs.push_back(ch);
                end
            end
            bhu_pkg::PH_BS_X: begin
                if (lo_nib[4]) begin
                    held_char = ch;
                    esc_phase = bhu_pkg::PH_DIGIT;
                end else begin
                    outs.push_back(bhu_pkg::BS_CHAR);
                    outs.push_back(bhu_pkg::X_CHAR);
                    esc_phase = bhu_pkg::PH_IDLE;
                    fresh = 1'b1;
                end
            end
            default: begin
                if (lo_nib[4]) begin
                    outs.push_back({hi_nib[3:0], lo_nib[3:0]});
                end else begin
                    outs.push_back(bhu_pkg::BS_CHAR);
                    outs.push_back(bhu_pkg::X_CHAR);
                    outs.push_back(held_char);
                    fresh = 1'b1;
                end
                esc_phase = bhu_pkg::PH_IDLE;
                held_char = 8'h00;
            end
        endcase
        // offending byte is taken again as if no escape were pending
        if (fresh) begin
            if (ch == bhu_pkg::BS_CHAR) begin
                esc_phase = bhu_pkg::PH_BS;
            end else begin
                outs.push_back(ch);
            end
        end
        if (fin) begin
            case (esc_phase)
                bhu_pkg::PH_BS: outs.push_back(bhu_pkg::BS_CHAR);
                bhu_pkg::PH_BS_X: begin
                    outs.push_back(bhu_pkg::BS_CHAR);
                    outs.push_back(bhu_pkg::X_CHAR);
                end
                bhu_pkg::PH_DIGIT: begin
                    outs.push_back(bhu_pkg::BS_CHAR);
                    outs.push_back(bhu_pkg::X_CHAR);
                    outs.push_back(held_char);
                end
                default: ;
            endcase
            esc_phase = bhu_pkg::PH_IDLE;
            held_char = 8'h00;
        end
        foreach (outs[i]) begin
            r.ch = outs[i];
            r.run_last = (i == outs.size() - 1);
            r.str_end = fin && (i == outs.size() - 1);
            plain_chars.push_back(r);
        end
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic fin);
        t_raw_char it;
        it.ch = ch;
        it.fin = fin;
        raw_chars.push_back(it);
    endtask

    function automatic logic end_roll();
        return $urandom_range(0, 11) == 0;
    endfunction

    function automatic logic [7:0] random_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'("0" + v);
        end
        if ($urandom_range(0, 1) == 1) begin
            return 8'("A" + v - 10);
        end
        return 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] ch;
        logic [4:0] nib;
        do begin
            ch = 8'($urandom);
            nib = hex_nibble(ch);
        end while (nib[4]);
        return ch;
    endfunction

    // driver: bursts of items separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_unescape(in_data, in_last);
                raw_chars.delete(0);
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0 || raw_chars.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data <= raw_chars[0].ch;
                    in_last <= raw_chars[0].fin;
                end
            end
        end
    end

    // monitor: checks each decoded byte, stalls on a rotating mask
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (plain_chars.size() == 0) begin
                    $error("unexpected result: out_byte %h", out_data);
                    errors++;
                end else begin
                    want = plain_chars.pop_front();
                    if (out_data !== want.ch) begin
                        $error("out_byte: expected %h, got %h", want.ch, out_data);
                        errors++;
                    end
                    if (out_run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, out_run_last);
                        errors++;
                    end
                    if (out_str_end !== want.str_end) begin
                        $error("string_end: expected %b, got %b", want.str_end, out_str_end);
                        errors++;
                    end
                end
            end
            mask_age++;
            if (mask_age >= 48) begin
                mask_age = 0;
                ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                if (ready_mask == 16'h0000) begin
                    ready_mask = 16'h0001;
                end
            end else begin
                ready_mask = {ready_mask[14:0], ready_mask[15]};
            end
            out_ready <= ready_mask[0];
        end
    end

    initial begin
        // plain extremes, escaped backslash
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        // decoded backslash is literal, the next byte is not escaped
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b0);
        queue_char("5", 1'b0);
        queue_char("c", 1'b0);
        queue_char("n", 1'b0);
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b0);
        queue_char("f", 1'b0);
        queue_char("F", 1'b0);
        // first digit missing
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b0);
        queue_char("g", 1'b0);
        // second digit missing, offending backslash opens a new escape
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b0);
        queue_char("A", 1'b0);
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b1);
        // four bytes out of one item at end of string
        queue_char(bhu_pkg::BS_CHAR, 1'b0);
        queue_char(bhu_pkg::X_CHAR, 1'b0);
        queue_char("9", 1'b0);
        queue_char(bhu_pkg::BS_CHAR, 1'b1);
        // lone backslash at end of string
        queue_char(bhu_pkg::BS_CHAR, 1'b1);
        directed_count = raw_chars.size();

        while (raw_chars.size() < directed_count + RANDOM_CHARS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                queue_char(8'($urandom), end_roll());
            end else if (pick < 5) begin
                queue_char(bhu_pkg::BS_CHAR, end_roll());
                queue_char(8'($urandom), end_roll());
            end else if (pick < 8) begin
                queue_char(bhu_pkg::BS_CHAR, end_roll());
                queue_char(bhu_pkg::X_CHAR, end_roll());
                queue_char(random_hex_char(), end_roll());
                queue_char(random_hex_char(), end_roll());
            end else if (pick < 9) begin
                queue_char(bhu_pkg::BS_CHAR, end_roll());
                queue_char(bhu_pkg::X_CHAR, end_roll());
                queue_char(8'($urandom), end_roll());
                queue_char(8'($urandom), end_roll());
            end else begin
                queue_char(bhu_pkg::BS_CHAR, end_roll());
                queue_char(bhu_pkg::X_CHAR, end_roll());
                queue_char(random_hex_char(), end_roll());
                c = random_non_hex();
                queue_char(c, end_roll());
            end
        end
        raw_chars[raw_chars.size() - 1].fin = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (raw_chars.size() != 0) @(posedge clk);
        while (plain_chars.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
